@@ sv/normal_pattern_reachability_macros.svh @@
// Assertion macros for the normal pattern reachability RTL.
// Depends on signals named clock and reset in the module that uses them.
`ifndef NORMAL_PATTERN_REACHABILITY_MACROS_SVH
`define NORMAL_PATTERN_REACHABILITY_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked at every rising clock edge outside reset
`define NPR_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("npr: same-cycle check failed");
// next-cycle implication
`define NPR_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("npr: next-cycle check failed");
`else
`define NPR_ASSERT_IMPL(name, ante, cons)
`define NPR_ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ sv/npr_pkg.sv @@
// Package for the normal pattern reachability block: sizes, codes, and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none
package npr_pkg;

   // table and bitset sizes
   localparam int MAX_ITEMS     = 64;
   localparam int MAX_POSITIONS = 1024;
   localparam int WORD_W        = 64;
   localparam int WORD_LOG2     = $clog2(WORD_W);
   localparam int NWORDS        = (MAX_POSITIONS + WORD_W - 1) / WORD_W;

   // field widths
   localparam int OPCODE_W    = 2;
   localparam int WIDTH_W     = 10;
   localparam int COUNT_W     = 8;
   localparam int QIDX_W      = 6;
   localparam int OUT_IDX_W   = 6;
   localparam int LEN_W       = 11;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   // derived widths
   localparam int ITEM_IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int ITEM_CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int QCMP_W      = (ITEM_CNT_W > QIDX_W) ? ITEM_CNT_W : QIDX_W;
   localparam int WORD_IDX_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int NW_W        = $clog2(NWORDS + 1);
   localparam int POS_W       = $clog2(MAX_POSITIONS);
   localparam int LEN_EFF_W   = $clog2(MAX_POSITIONS + 1);
   // doubling the item width
   localparam int SCALE_SHIFT = 1;
   localparam int SHIFT_W     = WIDTH_W + SCALE_SHIFT;
   localparam int EXT_A       = (LEN_W > LEN_EFF_W) ? LEN_W : LEN_EFF_W;
   localparam int EXT_W       = (EXT_A > SHIFT_W) ? EXT_A : SHIFT_W;

   // register index of pattern_length
   localparam logic REG_PATTERN_LENGTH = 1'b0;
   localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = LEN_W'(MAX_POSITIONS);

   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_QUERY = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SETUP,
      ST_SHIFT,
      ST_SEND,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic clear_table;
      logic load_item;
      logic start_query;
      logic fetch_item;
      logic setup_item;
      logic shift_copy;
      logic next_item;
      logic next_word;
      logic err_word;
   } cmd_type;

   typedef struct packed {
      logic query_ok;
      logic copies_done;
      logic item_last;
      logic word_last;
   } status_type;

endpackage
`default_nettype wire

@@ sv/normal_pattern_reachability.sv @@
// Normal pattern reachability over a table of up to 64 items; top level.
// Clear, load and unused opcodes complete on acceptance. A query is accepted, then for
// each stored item i come a table read, setup, c_i shift-or copies in the one 1024-bit
// unit and a step to close the item (c_i is 0 for a zero or too-wide step), then the
// result words in order, held under rsp_stall; an invalid index sends its error word
// the cycle after accept. Sync active-high reset empties the table, pattern_length 1024.
`default_nettype none
module normal_pattern_reachability (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [npr_pkg::OPCODE_W-1:0]   req_opcode,
   input  wire logic [npr_pkg::WIDTH_W-1:0]    req_item_width,
   input  wire logic [npr_pkg::COUNT_W-1:0]    req_item_count,
   input  wire logic [npr_pkg::QIDX_W-1:0]     req_query_index,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [npr_pkg::OUT_IDX_W-1:0]  rsp_word_index,
   output logic      [npr_pkg::WORD_W-1:0]     rsp_pattern_word,
   output logic                                rsp_error,
   output logic                                rsp_last,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [npr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [npr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [npr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);

   npr_pkg::cmd_type          cmd;
   npr_pkg::status_type       status;
   logic [npr_pkg::LEN_W-1:0] pattern_length;

   npr_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .pattern_length (pattern_length)
   );

   npr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_error  (rsp_error),
      .rsp_last   (rsp_last),
      .status     (status),
      .cmd        (cmd)
   );

   npr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_item_width   (req_item_width),
      .req_item_count   (req_item_count),
      .req_query_index  (req_query_index),
      .pattern_length   (pattern_length),
      .status           (status),
      .rsp_word_index   (rsp_word_index),
      .rsp_pattern_word (rsp_pattern_word)
   );

endmodule
`default_nettype wire

@@ sv/npr_csr.sv @@
// APB-style register port holding pattern_length.
// Depends on npr_pkg.
`default_nettype none
module npr_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [npr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [npr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [npr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   output logic      [npr_pkg::LEN_W-1:0]      pattern_length
);

   logic [npr_pkg::LEN_W-1:0] pattern_length_ff, pattern_length_in;
   logic                      reg_hit;

   // decode the word address; byte offsets inside the word are ignored
   assign reg_hit = (csr_paddr[2] == npr_pkg::REG_PATTERN_LENGTH) && (csr_paddr[1:0] == 2'b00
                    || csr_paddr[1:0] != 2'b00);

   // take the write on the access cycle
   always_comb begin
      pattern_length_in = pattern_length_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit) begin
         pattern_length_in = csr_pwdata[npr_pkg::LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= npr_pkg::PATTERN_LENGTH_RESET;
      end else begin
         pattern_length_ff <= pattern_length_in;
      end
   end

   assign csr_pready     = 1'b1;
   assign csr_prdata     = reg_hit ? npr_pkg::CSR_DATA_W'(pattern_length_ff) : '0;
   assign pattern_length = pattern_length_ff;

endmodule
`default_nettype wire

@@ sv/npr_datapath.sv @@
// Datapath: item table memory, reachability bitset with its shift-or unit,
// copy and word counters, result word select. Depends on npr_pkg and the macros.
`default_nettype none
`include "normal_pattern_reachability_macros.svh"
module npr_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire npr_pkg::cmd_type              cmd,
   input  wire logic [npr_pkg::WIDTH_W-1:0]   req_item_width,
   input  wire logic [npr_pkg::COUNT_W-1:0]   req_item_count,
   input  wire logic [npr_pkg::QIDX_W-1:0]    req_query_index,
   input  wire logic [npr_pkg::LEN_W-1:0]     pattern_length,
   output npr_pkg::status_type                status,
   output logic      [npr_pkg::OUT_IDX_W-1:0] rsp_word_index,
   output logic      [npr_pkg::WORD_W-1:0]    rsp_pattern_word
);

   // item table, written on load and read one entry per fetch
   logic [npr_pkg::WIDTH_W-1:0] width_mem [npr_pkg::MAX_ITEMS];
   logic [npr_pkg::COUNT_W-1:0] count_mem [npr_pkg::MAX_ITEMS];
   logic [npr_pkg::WIDTH_W-1:0] rd_width_ff;
   logic [npr_pkg::COUNT_W-1:0] rd_count_ff;

   logic [npr_pkg::ITEM_CNT_W-1:0]    items_loaded_ff, items_loaded_in;
   logic [npr_pkg::ITEM_IDX_W-1:0]    idx_ff, idx_in;
   logic [npr_pkg::QIDX_W-1:0]        q_ff, q_in;
   logic [npr_pkg::COUNT_W-1:0]       cnt_ff, cnt_in;
   logic [npr_pkg::SHIFT_W-1:0]       wid_ff, wid_in;
   logic [npr_pkg::WORD_IDX_W-1:0]    word_ff, word_in;
   logic [npr_pkg::MAX_POSITIONS-1:0] reach_ff, reach_in;

   logic                              table_full;
   logic [npr_pkg::LEN_EFF_W-1:0]     len_eff;
   logic [npr_pkg::NW_W-1:0]          nw;
   logic [npr_pkg::EXT_W:0]           nw_sum;
   logic [npr_pkg::MAX_POSITIONS-1:0] length_mask;
   logic                              shift_dead;
   logic                              own_item;
   logic [npr_pkg::POS_W-1:0]         word_base;

   assign table_full = (items_loaded_ff >= npr_pkg::ITEM_CNT_W'(npr_pkg::MAX_ITEMS));

   // saturate the length register into 1..MAX_POSITIONS
   always_comb begin
      if (pattern_length == '0) begin
         len_eff = npr_pkg::LEN_EFF_W'(1);
      end else if (npr_pkg::EXT_W'(pattern_length) > npr_pkg::EXT_W'(npr_pkg::MAX_POSITIONS)) begin
         len_eff = npr_pkg::LEN_EFF_W'(npr_pkg::MAX_POSITIONS);
      end else begin
         len_eff = npr_pkg::LEN_EFF_W'(pattern_length);
      end
   end

   // words in a run: ceiling of length over word width
   assign nw_sum      = (npr_pkg::EXT_W + 1)'(len_eff) + (npr_pkg::EXT_W + 1)'(npr_pkg::WORD_W - 1);
   assign nw          = npr_pkg::NW_W'(nw_sum >> npr_pkg::WORD_LOG2);
   assign length_mask = ~({npr_pkg::MAX_POSITIONS{1'b1}} << len_eff);

   // a copy of zero width or reaching past the pattern changes nothing
   assign shift_dead = (wid_ff == '0) ||
                       (npr_pkg::EXT_W'(wid_ff) >= npr_pkg::EXT_W'(len_eff));
   assign own_item   = (npr_pkg::QCMP_W'(idx_ff) == npr_pkg::QCMP_W'(q_ff));

   // status back to the controller
   assign status.query_ok    = (npr_pkg::QCMP_W'(req_query_index) <
                                npr_pkg::QCMP_W'(items_loaded_ff));
   assign status.copies_done = (cnt_ff == '0) || shift_dead;
   assign status.item_last   = ((npr_pkg::ITEM_CNT_W'(idx_ff) + npr_pkg::ITEM_CNT_W'(1)) ==
                                items_loaded_ff);
   assign status.word_last   = ((npr_pkg::NW_W'(word_ff) + npr_pkg::NW_W'(1)) == nw);

   // next values of counters and bitset
   always_comb begin
      items_loaded_in = items_loaded_ff;
      idx_in          = idx_ff;
      q_in            = q_ff;
      cnt_in          = cnt_ff;
      wid_in          = wid_ff;
      word_in         = word_ff;
      reach_in        = reach_ff;
      if (cmd.clear_table) begin
         items_loaded_in = '0;
      end
      if (cmd.load_item && !table_full) begin
         items_loaded_in = items_loaded_ff + npr_pkg::ITEM_CNT_W'(1);
      end
      if (cmd.start_query) begin
         idx_in   = '0;
         q_in     = req_query_index;
         word_in  = '0;
         reach_in = npr_pkg::MAX_POSITIONS'(1);
      end
      // load copy count, one fewer for the queried item
      if (cmd.setup_item) begin
         wid_in = npr_pkg::SHIFT_W'(rd_width_ff) << npr_pkg::SCALE_SHIFT;
         if (own_item && rd_count_ff != '0) begin
            cnt_in = rd_count_ff - npr_pkg::COUNT_W'(1);
         end else begin
            cnt_in = rd_count_ff;
         end
      end
      // one copy: shift-or masked to the pattern length
      if (cmd.shift_copy) begin
         reach_in = (reach_ff | (reach_ff << wid_ff)) & length_mask;
         cnt_in   = cnt_ff - npr_pkg::COUNT_W'(1);
      end
      if (cmd.next_item) begin
         idx_in = idx_ff + npr_pkg::ITEM_IDX_W'(1);
      end
      if (cmd.next_word) begin
         word_in = word_ff + npr_pkg::WORD_IDX_W'(1);
      end
   end

   // table memory: write on load, registered read on fetch
   always_ff @(posedge clock) begin
      if (cmd.load_item && !table_full) begin
         width_mem[items_loaded_ff[npr_pkg::ITEM_IDX_W-1:0]] <= req_item_width;
         count_mem[items_loaded_ff[npr_pkg::ITEM_IDX_W-1:0]] <= req_item_count;
      end
      if (cmd.fetch_item) begin
         rd_width_ff <= width_mem[idx_ff];
         rd_count_ff <= count_mem[idx_ff];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      wid_ff   <= wid_in;
      reach_ff <= reach_in;
   end

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         items_loaded_ff <= '0;
         word_ff         <= '0;
      end else begin
         items_loaded_ff <= items_loaded_in;
         word_ff         <= word_in;
      end
   end

   // select the word being sent; an error result carries zero
   assign word_base        = npr_pkg::POS_W'(word_ff) << npr_pkg::WORD_LOG2;
   assign rsp_word_index   = npr_pkg::OUT_IDX_W'(word_ff);
   assign rsp_pattern_word = cmd.err_word ? '0 : reach_ff[word_base +: npr_pkg::WORD_W];

   `NPR_ASSERT_IMPL(a_loaded_bound, 1'b1, items_loaded_ff <= npr_pkg::ITEM_CNT_W'(npr_pkg::MAX_ITEMS))
   `NPR_ASSERT_NEXT(a_full_load_dropped, cmd.load_item && table_full, $stable(items_loaded_ff))
   `NPR_ASSERT_NEXT(a_origin_kept, cmd.shift_copy, reach_ff[0])
   `NPR_ASSERT_IMPL(a_word_in_run, cmd.next_word, (npr_pkg::NW_W'(word_ff) + npr_pkg::NW_W'(1)) < nw)

endmodule
`default_nettype wire

@@ sv/npr_ctrl.sv @@
// Controller state machine: decodes requests, sequences fetch, setup and
// shift-or copies per item, then streams result words. Depends on npr_pkg.
`default_nettype none
module npr_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic [npr_pkg::OPCODE_W-1:0] req_opcode,
   output logic                              req_stall,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_error,
   output logic                              rsp_last,
   input  wire npr_pkg::status_type          status,
   output npr_pkg::cmd_type                  cmd
);

   npr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= npr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      rsp_error = 1'b0;
      rsp_last  = 1'b0;
      unique case (state_ff)
         npr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (npr_pkg::opcode_type'(req_opcode))
                  npr_pkg::OP_CLEAR: begin
                     cmd.clear_table = 1'b1;
                  end
                  npr_pkg::OP_LOAD: begin
                     cmd.load_item = 1'b1;
                  end
                  npr_pkg::OP_QUERY: begin
                     cmd.start_query = 1'b1;
                     state_in = status.query_ok ? npr_pkg::ST_FETCH : npr_pkg::ST_ERROR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         npr_pkg::ST_FETCH: begin
            cmd.fetch_item = 1'b1;
            state_in = npr_pkg::ST_SETUP;
         end
         npr_pkg::ST_SETUP: begin
            cmd.setup_item = 1'b1;
            state_in = npr_pkg::ST_SHIFT;
         end
         // one copy per cycle until the item is used up
         npr_pkg::ST_SHIFT: begin
            if (status.copies_done) begin
               if (status.item_last) begin
                  state_in = npr_pkg::ST_SEND;
               end else begin
                  cmd.next_item = 1'b1;
                  state_in = npr_pkg::ST_FETCH;
               end
            end else begin
               cmd.shift_copy = 1'b1;
            end
         end
         // one word per transfer
         npr_pkg::ST_SEND: begin
            rsp_valid = 1'b1;
            rsp_last  = status.word_last;
            if (!rsp_stall) begin
               if (status.word_last) begin
                  state_in = npr_pkg::ST_IDLE;
               end else begin
                  cmd.next_word = 1'b1;
               end
            end
         end
         npr_pkg::ST_ERROR: begin
            rsp_valid    = 1'b1;
            rsp_error    = 1'b1;
            rsp_last     = 1'b1;
            cmd.err_word = 1'b1;
            if (!rsp_stall) begin
               state_in = npr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = npr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ tb/sv/tb_normal_pattern_reachability.sv @@
`timescale 1ns / 1ps
// Testbench for normal_pattern_reachability: table clears, loads and pattern queries,
// checked word by word against a bitset predictor kept in this file. Depends on npr_pkg.
module tb_normal_pattern_reachability;

   localparam logic [npr_pkg::OPCODE_W-1:0]   OP_UNUSED           = 2'd3;
   localparam logic [npr_pkg::CSR_ADDR_W-1:0] PATTERN_LENGTH_ADDR =
      npr_pkg::CSR_ADDR_W'(4 * npr_pkg::REG_PATTERN_LENGTH);
   localparam logic [npr_pkg::CSR_ADDR_W-1:0] SPARE_REG_ADDR      =
      PATTERN_LENGTH_ADDR + npr_pkg::CSR_ADDR_W'(4);
   localparam int DRAIN_LIMIT   = 40000;
   localparam int SETTLE_CYCLES = 16;
   localparam int BATCH_ITEMS   = 20;

   typedef struct {
      logic [npr_pkg::OPCODE_W-1:0] opcode;
      logic [npr_pkg::WIDTH_W-1:0]  width;
      logic [npr_pkg::COUNT_W-1:0]  count;
      logic [npr_pkg::QIDX_W-1:0]   qidx;
   } table_op_type;

   typedef struct {
      logic [npr_pkg::OUT_IDX_W-1:0] word_index;
      logic [npr_pkg::WORD_W-1:0]    pattern_word;
      logic                          error;
      logic                          last;
   } pattern_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [npr_pkg::OPCODE_W-1:0]   req_opcode = '0;
   logic [npr_pkg::WIDTH_W-1:0]    req_item_width = '0;
   logic [npr_pkg::COUNT_W-1:0]    req_item_count = '0;
   logic [npr_pkg::QIDX_W-1:0]     req_query_index = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [npr_pkg::OUT_IDX_W-1:0]  rsp_word_index;
   logic [npr_pkg::WORD_W-1:0]     rsp_pattern_word;
   logic                           rsp_error;
   logic                           rsp_last;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [npr_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [npr_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [npr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // stimulus and scoreboard state
   table_op_type     pending_table_ops[$];
   pattern_word_type awaited_pattern_words[$];
   int               mismatch_count = 0;
   bit               idle_on = 1'b1;
   bit               req_went = 1'b0;
   int               req_gap = 0;
   int               rsp_hold = 0;
   int               gen_loaded = 0;

   // predictor copy of the block's table and register
   logic [npr_pkg::WIDTH_W-1:0] tbl_width[npr_pkg::MAX_ITEMS];
   logic [npr_pkg::COUNT_W-1:0] tbl_count[npr_pkg::MAX_ITEMS];
   int                          tbl_loaded = 0;
   logic [npr_pkg::LEN_W-1:0]   model_len = npr_pkg::PATTERN_LENGTH_RESET;

   normal_pattern_reachability u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_item_width   (req_item_width),
      .req_item_count   (req_item_count),
      .req_query_index  (req_query_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word_index   (rsp_word_index),
      .rsp_pattern_word (rsp_pattern_word),
      .rsp_error        (rsp_error),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Build the reachable set for query q and queue its words.
   function automatic void predict_pattern_words(int q);
      logic [npr_pkg::MAX_POSITIONS-1:0] reach;
      logic [npr_pkg::MAX_POSITIONS-1:0] keep;
      pattern_word_type                  word;
      int                                eff, nw, lim, step;
      if (q >= tbl_loaded) begin
         word.word_index   = '0;
         word.pattern_word = '0;
         word.error        = 1'b1;
         word.last         = 1'b1;
         awaited_pattern_words.push_back(word);
         return;
      end
      // saturate the length to 1..MAX_POSITIONS
      eff = int'(model_len);
      if (eff < 1) eff = 1;
      if (eff > npr_pkg::MAX_POSITIONS) eff = npr_pkg::MAX_POSITIONS;
      keep  = {npr_pkg::MAX_POSITIONS{1'b1}} >> (npr_pkg::MAX_POSITIONS - eff);
      reach = '0;
      reach[0] = 1'b1;
      for (int i = 0; i < tbl_loaded; i++) begin
         lim = int'(tbl_count[i]);
         if (i == q && lim > 0) lim--;
         step = 2 * int'(tbl_width[i]);
         // zero or oversized steps leave the set unchanged
         if (step != 0 && step < eff)
            for (int c = 0; c < lim; c++) reach = (reach | (reach << step)) & keep;
      end
      nw = (eff + npr_pkg::WORD_W - 1) / npr_pkg::WORD_W;
      for (int k = 0; k < nw; k++) begin
         word.word_index   = npr_pkg::OUT_IDX_W'(k);
         word.pattern_word = reach[k*npr_pkg::WORD_W +: npr_pkg::WORD_W];
         word.error        = 1'b0;
         word.last         = (k == nw - 1);
         awaited_pattern_words.push_back(word);
      end
   endfunction

   // Check result transfers, then track accepted requests and register writes.
   always @(posedge clock) begin
      pattern_word_type want;
      if (reset) begin
         req_went = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_pattern_words.size() == 0) begin
               $error("unexpected result: word_index %0d pattern_word %h error %0b last %0b",
                      rsp_word_index, rsp_pattern_word, rsp_error, rsp_last);
               mismatch_count++;
            end else begin
               want = awaited_pattern_words.pop_front();
               if (rsp_word_index !== want.word_index) begin
                  $error("word_index: expected %0d, actual %0d", want.word_index, rsp_word_index);
                  mismatch_count++;
               end
               if (rsp_pattern_word !== want.pattern_word) begin
                  $error("pattern_word: expected %h, actual %h",
                         want.pattern_word, rsp_pattern_word);
                  mismatch_count++;
               end
               if (rsp_error !== want.error) begin
                  $error("error: expected %0b, actual %0b", want.error, rsp_error);
                  mismatch_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
         req_went = req_valid && !req_stall;
         if (req_went) begin
            case (req_opcode)
               npr_pkg::OP_CLEAR: tbl_loaded = 0;
               npr_pkg::OP_LOAD: begin
                  // drop loads into a full table
                  if (tbl_loaded < npr_pkg::MAX_ITEMS) begin
                     tbl_width[tbl_loaded] = req_item_width;
                     tbl_count[tbl_loaded] = req_item_count;
                     tbl_loaded++;
                  end
               end
               npr_pkg::OP_QUERY: predict_pattern_words(int'(req_query_index));
               default: ;
            endcase
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == PATTERN_LENGTH_ADDR)
            model_len = csr_pwdata[npr_pkg::LEN_W-1:0];
      end
   end

   // Drive request transfers from the pending queue and stall results in bursts.
   always @(negedge clock) begin
      table_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (req_went || !req_valid) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_table_ops.size() != 0) begin
               op = pending_table_ops.pop_front();
               req_opcode      <= op.opcode;
               req_item_width  <= op.width;
               req_item_count  <= op.count;
               req_query_index <= op.qidx;
               req_valid       <= 1'b1;
               if (idle_on && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 13);
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_hold = $urandom_range(0, 12);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Queue one table operation and mirror the table fill for index picking.
   task automatic queue_op(input logic [npr_pkg::OPCODE_W-1:0] opc, input int w, input int c,
                           input int q);
      table_op_type op;
      op.opcode = opc;
      op.width  = npr_pkg::WIDTH_W'(w);
      op.count  = npr_pkg::COUNT_W'(c);
      op.qidx   = npr_pkg::QIDX_W'(q);
      pending_table_ops.push_back(op);
      if (opc == npr_pkg::OP_CLEAR) gen_loaded = 0;
      else if (opc == npr_pkg::OP_LOAD && gen_loaded < npr_pkg::MAX_ITEMS) gen_loaded++;
   endtask

   // Mostly clear/load/query sequences with random content, plus some noise.
   task automatic queue_random_traffic(input int n);
      int added, r, nload, nq, q;
      added = 0;
      while (added < n) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            if ($urandom_range(0, 1) == 1) begin
               queue_op(npr_pkg::OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 255),
                        $urandom_range(0, 63));
               added++;
            end
            nload = $urandom_range(1, 8);
            repeat (nload) begin
               queue_op(npr_pkg::OP_LOAD,
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(1, 40),
                        ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 5),
                        $urandom_range(0, 63));
               added++;
            end
            nq = $urandom_range(1, 4);
            repeat (nq) begin
               if (gen_loaded > 0 && $urandom_range(0, 4) != 0)
                  q = $urandom_range(0, gen_loaded - 1);
               else
                  q = $urandom_range(0, 63);
               queue_op(npr_pkg::OP_QUERY, $urandom_range(0, 1023), $urandom_range(0, 255), q);
               added++;
            end
         end else if (r < 90) begin
            // unused opcode: ignored by the block
            queue_op(OP_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 255),
                     $urandom_range(0, 63));
         end else begin
            queue_op(npr_pkg::OP_QUERY, $urandom_range(0, 1023), $urandom_range(0, 255),
                     $urandom_range(0, 63));
            added++;
         end
      end
   endtask

   // Wait for every transfer and expected word, then let the block settle.
   task automatic finish_batch();
      int waited;
      while (pending_table_ops.size() != 0 || req_valid) @(posedge clock);
      waited = 0;
      while (awaited_pattern_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (awaited_pattern_words.size() != 0) begin
         $error("%0d expected pattern words never arrived", awaited_pattern_words.size());
         mismatch_count++;
         awaited_pattern_words.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [npr_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [npr_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Sequence the run: directed checks at the reset length, then random phases.
   initial begin
      int phase_len[10];
      int len;
      phase_len = '{0, 1, 65, 2047, 64, 1025, 1024, 100, 513, 2};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table, unused opcode, then corner loads
      queue_op(npr_pkg::OP_QUERY, 1023, 255, 0);
      queue_op(OP_UNUSED, 1023, 255, 63);
      queue_op(npr_pkg::OP_LOAD, 1, 255, 0);
      queue_op(npr_pkg::OP_LOAD, 0, 3, 63);
      queue_op(npr_pkg::OP_LOAD, 1023, 2, 0);
      queue_op(npr_pkg::OP_LOAD, 3, 0, 21);
      queue_op(npr_pkg::OP_LOAD, 5, 1, 42);
      // queried item with many copies, zero copies, and a single copy
      queue_op(npr_pkg::OP_QUERY, 0, 0, 0);
      queue_op(npr_pkg::OP_QUERY, 682, 170, 3);
      queue_op(npr_pkg::OP_QUERY, 341, 85, 4);
      // index at and beyond the fill level
      queue_op(npr_pkg::OP_QUERY, 0, 0, 5);
      queue_op(npr_pkg::OP_QUERY, 1023, 255, 63);
      queue_op(npr_pkg::OP_CLEAR, 1023, 255, 63);
      queue_op(npr_pkg::OP_QUERY, 0, 0, 0);
      queue_op(npr_pkg::OP_LOAD, 512, 1, 0);
      queue_op(npr_pkg::OP_LOAD, 31, 4, 0);
      queue_op(npr_pkg::OP_QUERY, 0, 0, 1);
      queue_op(npr_pkg::OP_QUERY, 0, 0, 0);
      finish_batch();

      for (int p = 0; p < 10; p++) begin
         len = (p == 8) ? $urandom_range(1, 1024) : phase_len[p];
         csr_write(PATTERN_LENGTH_ADDR,
                   {(npr_pkg::CSR_DATA_W - npr_pkg::LEN_W)'($urandom),
                    npr_pkg::LEN_W'(len)});
         // a write to an address with no register must leave the length alone
         if (p == 3) csr_write(SPARE_REG_ADDR, $urandom);
         if (p == 9) idle_on = 1'b0;
         if (p == 4) begin
            // overfill the table so the last loads are dropped
            queue_op(npr_pkg::OP_CLEAR, 0, 0, 0);
            repeat (npr_pkg::MAX_ITEMS + 2)
               queue_op(npr_pkg::OP_LOAD, $urandom_range(1, 40), $urandom_range(0, 2),
                        $urandom_range(0, 63));
            queue_op(npr_pkg::OP_QUERY, 0, 0, 0);
            queue_op(npr_pkg::OP_QUERY, 0, 0, npr_pkg::MAX_ITEMS - 1);
            queue_op(npr_pkg::OP_QUERY, 0, 0, $urandom_range(0, 63));
         end
         queue_random_traffic(BATCH_ITEMS);
         finish_batch();
      end

      if (mismatch_count == 0) begin
         $display("PASS normal_pattern_reachability");
      end else begin
         $display("FAIL normal_pattern_reachability");
      end
      $finish;
   end

   // Watchdog on the whole run.
   initial begin
      #100_000_000;
      $display("FAIL normal_pattern_reachability");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/npr_pkg.sv
sv/npr_csr.sv
sv/npr_datapath.sv
sv/npr_ctrl.sv
sv/normal_pattern_reachability.sv
tb/sv/tb_normal_pattern_reachability.sv
